// ===== hdl/tdpc_pkg.sv =====
package tdpc_pkg;

   // Candidate and count width.
   localparam int VALUE_WIDTH = 16;
   // Divisor register: holds sqrt(2^VALUE_WIDTH) plus one step of two, with headroom.
   localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 2;
   localparam int SQ_WIDTH = 2 * DIV_WIDTH;
   localparam int BIT_IDX_WIDTH = $clog2(VALUE_WIDTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_LEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Even candidates are filtered out up front, so trial divisors start at three.
   localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(3);
   localparam logic [SQ_WIDTH-1:0] FIRST_SQUARE = SQ_WIDTH'(9);

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] candidate;
      logic                   restart;
   } req_type;

   typedef struct packed {
      logic                   is_prime;
      logic [VALUE_WIDTH-1:0] prime_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_COMPOSITE,
      CLS_PRIME,
      CLS_TRIAL
   } class_type;

   typedef struct packed {
      req_type   item;
      class_type cls;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_REPORT
   } back_state_type;

endpackage

// ===== hdl/tdpc_front.sv =====
module tdpc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tdpc_pkg::req_type          req_data,
   output logic                       push_valid,
   output tdpc_pkg::entry_type        push_entry,
   input  tdpc_pkg::queue_status_type q_status
);
   import tdpc_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   class_type cls;
   logic      accept;

   // Cheap cases settle here; only odd candidates of five and up need the divider.
   always_comb begin
      if (req_data.candidate < VALUE_WIDTH'(2)) begin
         cls = CLS_COMPOSITE;
      end else if (req_data.candidate < VALUE_WIDTH'(4)) begin
         cls = CLS_PRIME;
      end else if (!req_data.candidate[0]) begin
         cls = CLS_COMPOSITE;
      end else begin
         cls = CLS_TRIAL;
      end
   end

   assign req_stall  = valid_ff && q_status.full;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      valid_in = valid_ff && q_status.full;
      entry_in = entry_ff;
      if (accept) begin
         valid_in = 1'b1;
         entry_in = '{item: req_data, cls: cls};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/tdpc_queue.sv =====
module tdpc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  tdpc_pkg::entry_type        push_entry,
   input  logic                       pop,
   output tdpc_pkg::entry_type        head,
   output tdpc_pkg::queue_status_type q_status
);
   import tdpc_pkg::*;

   entry_type                    slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                         do_push, do_pop;

   assign q_status.full  = (level_ff == QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH));
   assign q_status.empty = (level_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/tdpc_back.sv =====
module tdpc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tdpc_pkg::queue_status_type q_status,
   input  tdpc_pkg::entry_type        head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tdpc_pkg::rsp_type          rsp_data
);
   import tdpc_pkg::*;

   back_state_type             state_ff, state_in;
   logic [VALUE_WIDTH-1:0]     cand_ff, cand_in;
   logic                       restart_ff, restart_in;
   logic                       prime_ff, prime_in;
   logic [DIV_WIDTH-1:0]       div_ff, div_in;
   logic [SQ_WIDTH-1:0]        sq_ff, sq_in;
   logic [DIV_WIDTH-1:0]       rem_ff, rem_in;
   logic [BIT_IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0]     count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       slot_free;
   logic [DIV_WIDTH:0]         shifted;
   logic [DIV_WIDTH:0]         diff;
   logic [DIV_WIDTH-1:0]       rem_next;
   logic [VALUE_WIDTH-1:0]     count_base;
   logic [VALUE_WIDTH-1:0]     count_new;

   // One restoring-remainder step per cycle, MSB of the candidate first.
   assign shifted  = {rem_ff, cand_ff[idx_ff]};
   assign diff     = shifted - {1'b0, div_ff};
   assign rem_next = (shifted >= {1'b0, div_ff}) ? diff[DIV_WIDTH-1:0]
                                                 : shifted[DIV_WIDTH-1:0];

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign count_base = restart_ff ? '0 : count_ff;
   assign count_new  = (prime_ff && (count_base != '1)) ? count_base + 1'b1 : count_base;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      restart_in   = restart_ff;
      prime_in     = prime_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop        = 1'b1;
               cand_in    = head.item.candidate;
               restart_in = head.item.restart;
               prime_in   = (head.cls == CLS_PRIME);
               div_in     = FIRST_DIVISOR;
               sq_in      = FIRST_SQUARE;
               state_in   = (head.cls == CLS_TRIAL) ? ST_CHECK : ST_REPORT;
            end
         end
         ST_CHECK: begin
            if (sq_ff > SQ_WIDTH'(cand_ff)) begin
               // No divisor up to the square root: prime.
               prime_in = 1'b1;
               state_in = ST_REPORT;
            end else begin
               rem_in   = '0;
               idx_in   = BIT_IDX_WIDTH'(VALUE_WIDTH - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_next;
            idx_in = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               if (rem_next == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_REPORT;
               end else begin
                  // (d+2)^2 = d^2 + 4d + 4
                  div_in   = div_ff + DIV_WIDTH'(2);
                  sq_in    = sq_ff + SQ_WIDTH'({div_ff, 2'b00}) + SQ_WIDTH'(4);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               count_in     = count_new;
               rsp_in       = '{is_prime: prime_ff, prime_count: count_new};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      restart_ff <= restart_in;
      prime_ff   <= prime_in;
      div_ff     <= div_in;
      sq_ff      <= sq_in;
      rem_ff     <= rem_in;
      idx_ff     <= idx_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== hdl/trial_division_prime_counter_top.sv =====
// Channel   Dir  Handshake              Word
// req       in   req_valid / req_stall  req_data  (candidate, restart)
// rsp       out  rsp_valid / rsp_stall  rsp_data  (is_prime, prime_count)
//
// 0, 1, 2, 3 and even candidates are settled in the front and need no division.
// Odd candidates of 5 and up run a bit-serial remainder over the 16-bit candidate,
// one remainder pass per odd trial divisor 3, 5, 7, ... while d*d <= candidate; the
// worst case is 127 divisors. All of it runs in the single divider in the back end.
// Reset: synchronous, clears the prime count, the queue and all valid flags.
// Stalls: a two-word queue and the front register keep taking words while the back
// end works; the result register holds its word while rsp_stall is high.
module trial_division_prime_counter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tdpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tdpc_pkg::rsp_type rsp_data
);
   import tdpc_pkg::*;

   // front -> queue
   logic             push_valid;
   entry_type        push_entry;
   // queue <-> back
   queue_status_type q_status;
   entry_type        head;
   logic             pop;

   // Front: registers the word and sorts out the cases that need no division.
   tdpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_status   (q_status)
   );

   // Short queue decoupling intake from the divider.
   tdpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // Back: trial division, running count with saturation, result register.
   tdpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/trial_division_prime_counter_top_test.sv =====
`timescale 1ns / 100ps

module trial_division_prime_counter_top_test;
   import tdpc_pkg::*;

   // Cycles with no word moving on either channel before the run is declared hung.
   // It stays well above the slowest candidate plus the long receiver hold-off.
   localparam int IDLE_LIMIT      = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_WORDS  = 12;
   localparam int RANDOM_WORDS    = 100;
   localparam int TAIL_CYCLES     = 64;
   // Short run of fast prime words right after a restart.
   localparam int FILL_WORDS      = 8;

   // Receiver stall modes, one per stretch.
   localparam int STALL_NONE  = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;

   localparam int DIRECTED_WORDS = 20;
   // Directed words: zero and one, two and three, four (inclusive bound), small odd
   // squares, field extremes, restart on prime and composite words.
   localparam logic [VALUE_WIDTH-1:0] DIRECTED_CANDIDATES [DIRECTED_WORDS] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49, 16'd65535,
      16'd65521, 16'd65534, 16'd32768, 16'd2, 16'd4, 16'd7, 16'd63001, 16'd16383,
      16'd65521, 16'd0
   };
   localparam logic [DIRECTED_WORDS-1:0] DIRECTED_RESTARTS = 20'b1000_0100_0100_0000_0001;

   // Scoreboard: predicts the result word for each accepted request word and
   // compares results against the oldest prediction.
   class prime_tally_board;
      rsp_type                expected_words[$];
      logic [VALUE_WIDTH-1:0] running_count = '0;
      int                     error_count   = 0;

      static function bit is_prime_number(logic [VALUE_WIDTH-1:0] n);
         longint unsigned value;
         longint unsigned divisor;
         value = n;
         if (value < 2) return 1'b0;
         for (divisor = 2; divisor * divisor <= value; divisor++) begin
            if (value % divisor == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void flag_error(string what);
         error_count++;
         if (error_count <= 10) $display("mismatch: %s", what);
      endfunction

      function void note_request(req_type word);
         rsp_type predicted;
         bit      prime;
         prime = is_prime_number(word.candidate);
         if (word.restart) running_count = '0;
         // count saturates at all ones
         if (prime && running_count != '1) running_count = running_count + 1'b1;
         predicted.is_prime    = prime;
         predicted.prime_count = running_count;
         expected_words.push_back(predicted);
      endfunction

      function void check_response(rsp_type word);
         rsp_type predicted;
         if (expected_words.size() == 0) begin
            flag_error($sformatf("unexpected word is_prime %0b prime_count %0d",
                                 word.is_prime, word.prime_count));
            return;
         end
         predicted = expected_words.pop_front();
         if (word.is_prime !== predicted.is_prime)
            flag_error($sformatf("is_prime expected %0b got %0b",
                                 predicted.is_prime, word.is_prime));
         if (word.prime_count !== predicted.prime_count)
            flag_error($sformatf("prime_count expected %0d got %0d",
                                 predicted.prime_count, word.prime_count));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   prime_tally_board board;

   // Sender burst state.
   int burst_left = 0;
   // Receiver state: pattern on/off, long hold-off request, stretch bookkeeping.
   bit rx_pattern_on  = 1'b0;
   bit hold_off_armed = 1'b0;
   int hold_left      = 0;
   int segment_left   = 0;
   int stall_mode     = STALL_NONE;
   int idle_cycles    = 0;

   trial_division_prime_counter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Channel monitors, sampled at the rising edge. Results are checked before the
   // request of the same edge is noted; that request cannot have its result yet.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
         if (req_valid && !req_stall) board.note_request(req_data);
      end
   end

   // Watchdog: ends the run if nothing moves for too long.
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: stalls in stretches of random mode; a requested hold-off keeps
   // rsp_stall high for a fixed count of cycles, counted here.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_left      = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!rx_pattern_on) begin
            rsp_stall <= 1'b0;
         end else begin
            if (segment_left == 0) begin
               segment_left = $urandom_range(16, 96);
               stall_mode   = $urandom_range(STALL_NONE, STALL_HEAVY);
            end
            segment_left--;
            case (stall_mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
            endcase
         end
      end
   end

   // Offers one word from a falling edge, holds it until accepted, and returns at
   // the next falling edge. With gaps on, a random idle gap may follow a burst.
   task automatic send_word(input req_type word, input bit gaps_on);
      int gap;
      req_data  <= word;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.expected_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_type                word;
      logic [VALUE_WIDTH-1:0] odd_factor;

      board     = new;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words, idling on both sides.
      rx_pattern_on = 1'b1;
      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         word.candidate = DIRECTED_CANDIDATES[i];
         word.restart   = DIRECTED_RESTARTS[DIRECTED_WORDS-1-i];
         send_word(word, 1'b1);
      end
      wait_drained();

      // Restart, then a back-to-back run of the fast primes two and three;
      // then a composite and a restart on a prime.
      rx_pattern_on = 1'b0;
      for (int i = 0; i < FILL_WORDS; i++) begin
         word.candidate = (i % 2 == 0) ? VALUE_WIDTH'(2) : VALUE_WIDTH'(3);
         word.restart   = (i == 0);
         send_word(word, 1'b0);
      end
      word.candidate = VALUE_WIDTH'(4);
      word.restart   = 1'b0;
      send_word(word, 1'b0);
      word.candidate = VALUE_WIDTH'(3);
      word.restart   = 1'b1;
      send_word(word, 1'b0);
      wait_drained();

      // Random words with idling on both sides.
      rx_pattern_on = 1'b1;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 3) begin
            // Long receiver hold-off while small words keep coming back to back,
            // so the queue fills and req_stall rises.
            hold_off_armed = 1'b1;
            for (int k = 0; k < HOLD_OFF_WORDS; k++) begin
               word.candidate = VALUE_WIDTH'($urandom_range(0, 40));
               word.restart   = 1'b0;
               send_word(word, 1'b0);
            end
         end
         if (i == 2 * RANDOM_WORDS / 3) wait_drained();
         case ($urandom_range(0, 3))
            0: begin
               word.candidate = VALUE_WIDTH'($urandom_range(0, 20));
            end
            1: begin
               word.candidate = VALUE_WIDTH'($urandom);
            end
            2: begin
               // nearest prime at or below a random value; wraps past zero
               word.candidate = VALUE_WIDTH'($urandom);
               while (!prime_tally_board::is_prime_number(word.candidate))
                  word.candidate = word.candidate - 1'b1;
            end
            default: begin
               // odd square, divisor exactly at the bound
               odd_factor     = VALUE_WIDTH'($urandom_range(1, 127) * 2 + 1);
               word.candidate = VALUE_WIDTH'(odd_factor * odd_factor);
            end
         endcase
         word.restart = ($urandom_range(0, 15) == 0);
         send_word(word, 1'b1);
      end
      wait_drained();

      // Let any stray result show up before the verdict.
      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.error_count == 0 && board.expected_words.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tdpc_pkg.sv
hdl/tdpc_front.sv
hdl/tdpc_queue.sv
hdl/tdpc_back.sv
hdl/trial_division_prime_counter_top.sv
dv/trial_division_prime_counter_top_test.sv
